@@ hw/rtl/sit_pkg.sv @@
// shared types, widths and arithmetic helpers for the segment intersection test
package sit_pkg;

    // coordinate width and derived arithmetic widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = 2 * DIFF_W;
    localparam int PROD_W  = 2 * COORD_W + 3;

    // stream widths
    localparam int S_DATA_W = ((8 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;

    // the two segments as received
    typedef struct packed {
        logic signed [COORD_W-1:0] q2y;
        logic signed [COORD_W-1:0] q2x;
        logic signed [COORD_W-1:0] q1y;
        logic signed [COORD_W-1:0] q1x;
        logic signed [COORD_W-1:0] p2y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p1x;
    } seg_pair_t;

    // direction vectors and endpoint offsets
    typedef struct packed {
        logic signed [DIFF_W-1:0] ux;
        logic signed [DIFF_W-1:0] uy;
        logic signed [DIFF_W-1:0] wx;
        logic signed [DIFF_W-1:0] wy;
        logic signed [DIFF_W-1:0] aq1x;
        logic signed [DIFF_W-1:0] aq1y;
        logic signed [DIFF_W-1:0] aq2x;
        logic signed [DIFF_W-1:0] aq2y;
        logic signed [DIFF_W-1:0] bp1x;
        logic signed [DIFF_W-1:0] bp1y;
        logic signed [DIFF_W-1:0] bp2x;
        logic signed [DIFF_W-1:0] bp2y;
    } diff_t;

    // cross products, squared lengths and projections
    typedef struct packed {
        logic signed [PROD_W-1:0] a11;
        logic signed [PROD_W-1:0] a12;
        logic signed [PROD_W-1:0] a21;
        logic signed [PROD_W-1:0] a22;
        logic signed [PROD_W-1:0] len1;
        logic signed [PROD_W-1:0] len2;
        logic signed [PROD_W-1:0] tp1;
        logic signed [PROD_W-1:0] tp2;
        logic signed [PROD_W-1:0] tq1;
        logic signed [PROD_W-1:0] tq2;
        logic                     starts_equal;
    } prod_t;

    // signed difference of two coordinates, one bit wider
    function automatic logic signed [DIFF_W-1:0] sub_c(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] ea;
        logic signed [DIFF_W-1:0] eb;
        ea = DIFF_W'(a);
        eb = DIFF_W'(b);
        return ea - eb;
    endfunction

    // 2-D cross product ax*by - ay*bx
    function automatic logic signed [PROD_W-1:0] cross2(
        input logic signed [DIFF_W-1:0] ax,
        input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] bx,
        input logic signed [DIFF_W-1:0] by
    );
        logic signed [MUL_W-1:0] m1;
        logic signed [MUL_W-1:0] m2;
        m1 = ax * by;
        m2 = ay * bx;
        return PROD_W'(m1) - PROD_W'(m2);
    endfunction

    // 2-D dot product ax*bx + ay*by
    function automatic logic signed [PROD_W-1:0] dot2(
        input logic signed [DIFF_W-1:0] ax,
        input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] bx,
        input logic signed [DIFF_W-1:0] by
    );
        logic signed [MUL_W-1:0] m1;
        logic signed [MUL_W-1:0] m2;
        m1 = ax * bx;
        m2 = ay * by;
        return PROD_W'(m1) + PROD_W'(m2);
    endfunction

endpackage

@@ hw/rtl/segment_intersection_test.sv @@
// stages from input transaction to result: differences, products, decision, each registered
// throughput: one segment pair per cycle while the result side is ready; each stage register takes a new transaction
// whenever it is empty or its contents move on, so bubbles close up under stall
// reset: synchronous active-low aresetn empties all stages; no other state is kept
// top level of the closed 2-D segment intersection test
module segment_intersection_test (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // p_start_x, p_start_y, p_end_x, p_end_y, q_start_x, q_start_y, q_end_x, q_end_y
    input  logic [sit_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // segments_meet, then zero fill
    output logic [sit_pkg::M_DATA_W-1:0] m_axis_tdata
);

    sit_pkg::seg_pair_t pts;
    sit_pkg::diff_t     diff;
    sit_pkg::prod_t     prod;
    logic               v1;
    logic               v2;
    logic               v3;
    logic               en1;
    logic               en2;
    logic               en3;
    logic               meet;

    // per-stage advance: a stage loads when empty or when its contents move on
    assign en3 = !v3 || m_axis_tready;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;
    assign s_axis_tready = en1;

    // unpack the input transaction
    assign pts = sit_pkg::seg_pair_t'(s_axis_tdata[8*sit_pkg::COORD_W-1:0]);

    sit_diff_stage u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en1),
        .valid_in  (s_axis_tvalid),
        .pts       (pts),
        .valid_out (v1),
        .diff_out  (diff)
    );

    sit_prod_stage u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en2),
        .valid_in  (v1),
        .d         (diff),
        .valid_out (v2),
        .prod_out  (prod)
    );

    sit_decide_stage u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en3),
        .valid_in  (v2),
        .p         (prod),
        .valid_out (v3),
        .meet_out  (meet)
    );

    // result transaction
    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = {{(sit_pkg::M_DATA_W-1){1'b0}}, meet};

endmodule

@@ hw/rtl/sit_diff_stage.sv @@
// first stage: coordinate differences into the input register
module sit_diff_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  sit_pkg::seg_pair_t pts,
    output logic               valid_out,
    output sit_pkg::diff_t     diff_out
);

    logic           valid_reg;
    sit_pkg::diff_t diff_reg;
    sit_pkg::diff_t diff_next;

    // direction vectors and offsets from each segment start
    always_comb begin
        diff_next.ux   = sit_pkg::sub_c(pts.p2x, pts.p1x);
        diff_next.uy   = sit_pkg::sub_c(pts.p2y, pts.p1y);
        diff_next.wx   = sit_pkg::sub_c(pts.q2x, pts.q1x);
        diff_next.wy   = sit_pkg::sub_c(pts.q2y, pts.q1y);
        diff_next.aq1x = sit_pkg::sub_c(pts.q1x, pts.p1x);
        diff_next.aq1y = sit_pkg::sub_c(pts.q1y, pts.p1y);
        diff_next.aq2x = sit_pkg::sub_c(pts.q2x, pts.p1x);
        diff_next.aq2y = sit_pkg::sub_c(pts.q2y, pts.p1y);
        diff_next.bp1x = sit_pkg::sub_c(pts.p1x, pts.q1x);
        diff_next.bp1y = sit_pkg::sub_c(pts.p1y, pts.q1y);
        diff_next.bp2x = sit_pkg::sub_c(pts.p2x, pts.q1x);
        diff_next.bp2y = sit_pkg::sub_c(pts.p2y, pts.q1y);
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
        end
    end

    assign valid_out = valid_reg;
    assign diff_out  = diff_reg;

endmodule

@@ hw/rtl/sit_prod_stage.sv @@
// second stage: cross and dot products
module sit_prod_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  sit_pkg::diff_t d,
    output logic           valid_out,
    output sit_pkg::prod_t prod_out
);

    logic           valid_reg;
    sit_pkg::prod_t prod_reg;
    sit_pkg::prod_t prod_next;

    // side tests against each line, lengths and projections
    always_comb begin
        prod_next.a11  = sit_pkg::cross2(d.ux, d.uy, d.aq1x, d.aq1y);
        prod_next.a12  = sit_pkg::cross2(d.ux, d.uy, d.aq2x, d.aq2y);
        prod_next.a21  = sit_pkg::cross2(d.wx, d.wy, d.bp1x, d.bp1y);
        prod_next.a22  = sit_pkg::cross2(d.wx, d.wy, d.bp2x, d.bp2y);
        prod_next.len1 = sit_pkg::dot2(d.ux, d.uy, d.ux, d.uy);
        prod_next.len2 = sit_pkg::dot2(d.wx, d.wy, d.wx, d.wy);
        prod_next.tp1  = sit_pkg::dot2(d.aq1x, d.aq1y, d.ux, d.uy);
        prod_next.tp2  = sit_pkg::dot2(d.aq2x, d.aq2y, d.ux, d.uy);
        prod_next.tq1  = sit_pkg::dot2(d.bp1x, d.bp1y, d.wx, d.wy);
        prod_next.tq2  = sit_pkg::dot2(d.bp2x, d.bp2y, d.wx, d.wy);
        prod_next.starts_equal = (d.bp1x == '0) && (d.bp1y == '0);
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign valid_out = valid_reg;
    assign prod_out  = prod_reg;

endmodule

@@ hw/rtl/sit_decide_stage.sv @@
// third stage: sign and range decisions into the result register
module sit_decide_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  sit_pkg::prod_t p,
    output logic           valid_out,
    output logic           meet_out
);

    logic valid_reg;
    logic meet_reg;
    logic meet_next;
    logic on_p_line;
    logic on_q_line;
    logic p_straddle;
    logic q_straddle;
    logic p_longer;
    logic q_proper;
    logic ovl_p;
    logic ovl_q;

    // straddle tests and interval overlap on the longer segment
    always_comb begin
        on_p_line  = (p.a11 == '0) && (p.a12 == '0);
        on_q_line  = (p.a21 == '0) && (p.a22 == '0);
        p_straddle = ((p.a11 >= 0) && (p.a12 <= 0)) || ((p.a11 <= 0) && (p.a12 >= 0));
        q_straddle = ((p.a21 >= 0) && (p.a22 <= 0)) || ((p.a21 <= 0) && (p.a22 >= 0));
        p_longer   = p.len1 > p.len2;
        q_proper   = p.len2 > 0;
        ovl_p      = ((p.tp1 <= p.len1) || (p.tp2 <= p.len1)) &&
                     ((p.tp1 >= 0) || (p.tp2 >= 0));
        ovl_q      = ((p.tq1 <= p.len2) || (p.tq2 <= p.len2)) &&
                     ((p.tq1 >= 0) || (p.tq2 >= 0));
        priority if (on_p_line) begin
            priority if (p_longer) begin
                meet_next = ovl_p;
            end else if (q_proper) begin
                meet_next = on_q_line && ovl_q;
            end else begin
                meet_next = p.starts_equal;
            end
        end else if (p_straddle) begin
            meet_next = q_straddle;
        end else begin
            meet_next = 1'b0;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (en) begin
            meet_reg <= meet_next;
        end
    end

    assign valid_out = valid_reg;
    assign meet_out  = meet_reg;

endmodule

@@ tb/tb_segment_intersection_test.sv @@
// testbench for the segment intersection test: stream stimulus and result checking
`timescale 1ns / 1ps

module tb_segment_intersection_test;

    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 257;
    localparam int NUM_PHASES       = 4;
    localparam int HOLD_OFF_CYCLES  = 150;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int TAIL_CYCLES      = 12;
    localparam int STALL_LIMIT      = 2000;

    // scoreboard: predicts the meet flag per pair and checks results in order
    class meet_scoreboard;
        bit          expected_meet[$];
        int unsigned n_pairs;
        int unsigned n_results;
        int unsigned n_meets;
        int unsigned n_collinear;
        int unsigned n_degenerate;
        int unsigned n_errors;

        function new();
            n_pairs      = 0;
            n_results    = 0;
            n_meets      = 0;
            n_collinear  = 0;
            n_degenerate = 0;
            n_errors     = 0;
        endfunction

        // either value zero, or the two of opposite sign
        function bit on_or_across(longint a, longint b);
            return (a >= 0 && b <= 0) || (a <= 0 && b >= 0);
        endfunction

        // closed range [0, len] against the span of two projections
        function bit span_hits(longint len, longint t0, longint t1);
            longint lo;
            longint hi;
            lo = (t0 < t1) ? t0 : t1;
            hi = (t0 < t1) ? t1 : t0;
            return lo <= len && hi >= 0;
        endfunction

        // exact integer decision: cross products, then dot products when collinear
        function bit predict_meet(sit_pkg::seg_pair_t pr);
            longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
            longint ux, uy, wx, wy;
            longint cq1, cq2, cp1, cp2;
            longint len_p, len_q;
            bit     hit;
            p1x = pr.p1x;
            p1y = pr.p1y;
            p2x = pr.p2x;
            p2y = pr.p2y;
            q1x = pr.q1x;
            q1y = pr.q1y;
            q2x = pr.q2x;
            q2y = pr.q2y;
            ux  = p2x - p1x;
            uy  = p2y - p1y;
            wx  = q2x - q1x;
            wy  = q2y - q1y;
            cq1 = ux * (q1y - p1y) - uy * (q1x - p1x);
            cq2 = ux * (q2y - p1y) - uy * (q2x - p1x);
            cp1 = wx * (p1y - q1y) - wy * (p1x - q1x);
            cp2 = wx * (p2y - q1y) - wy * (p2x - q1x);
            if ((ux == 0 && uy == 0) || (wx == 0 && wy == 0))
                n_degenerate++;
            if (cq1 == 0 && cq2 == 0) begin
                n_collinear++;
                len_p = ux * ux + uy * uy;
                len_q = wx * wx + wy * wy;
                // project onto the longer one; a tie goes to q
                if (len_p > len_q) begin
                    hit = span_hits(len_p, (q1x - p1x) * ux + (q1y - p1y) * uy,
                                    (q2x - p1x) * ux + (q2y - p1y) * uy);
                end else if (len_q > 0) begin
                    // a point p must also sit on the line of q
                    hit = cp1 == 0 && cp2 == 0 &&
                          span_hits(len_q, (p1x - q1x) * wx + (p1y - q1y) * wy,
                                    (p2x - q1x) * wx + (p2y - q1y) * wy);
                end else begin
                    hit = (p1x == q1x) && (p1y == q1y);
                end
            end else if (on_or_across(cq1, cq2)) begin
                hit = on_or_across(cp1, cp2);
            end else begin
                hit = 1'b0;
            end
            return hit;
        endfunction

        function void note_pair(sit_pkg::seg_pair_t pr);
            bit hit;
            hit = predict_meet(pr);
            expected_meet = {expected_meet, hit};
            n_pairs++;
            if (hit)
                n_meets++;
        endfunction

        function void check_result(logic [sit_pkg::M_DATA_W-1:0] data);
            bit want;
            n_results++;
            if (expected_meet.size() == 0) begin
                n_errors++;
                $display("%0t: result %0d with no pair pending: expected none, actual %h",
                         $time, n_results, data);
                return;
            end
            want = expected_meet.pop_front();
            if (data[0] !== want || data[sit_pkg::M_DATA_W-1:1] !== '0) begin
                n_errors++;
                $display("%0t: result %0d segments_meet: expected %0d, actual %h",
                         $time, n_results, want, data);
            end
        endfunction

        function int pending();
            return expected_meet.size();
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [sit_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [sit_pkg::M_DATA_W-1:0] m_axis_tdata;

    meet_scoreboard sb;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_req   = 1'b0;
    int  quiet_cycles   = 0;

    segment_intersection_test dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // p_start_x, p_start_y, p_end_x, p_end_y, q_start_x, q_start_y, q_end_x, q_end_y
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // segments_meet, then zero fill
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // result side ready, with random stalls and a single long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor both channels and feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pair(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic sit_pkg::seg_pair_t make_pair(int p1x, int p1y, int p2x, int p2y,
                                                     int q1x, int q1y, int q2x, int q2y);
        sit_pkg::seg_pair_t pr;
        pr.p1x = 16'(p1x);
        pr.p1y = 16'(p1y);
        pr.p2x = 16'(p2x);
        pr.p2y = 16'(p2y);
        pr.q1x = 16'(q1x);
        pr.q1y = 16'(q1y);
        pr.q2x = 16'(q2x);
        pr.q2y = 16'(q2y);
        return pr;
    endfunction

    // mix of raw bits, corner values, tight clusters and points along a common line
    function automatic sit_pkg::seg_pair_t random_pair();
        int corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        int c[8];
        int kind, mode, bx, by, dx, dy, span, dmax;
        int t0, t1, t2, t3, k;
        sit_pkg::seg_pair_t pr;
        kind = $urandom_range(9);
        if (kind <= 1) begin
            pr = {$urandom(), $urandom(), $urandom(), $urandom()};
            return pr;
        end
        if (kind == 2) begin
            foreach (c[i])
                c[i] = corner[$urandom_range(6)];
        end else if (kind <= 4) begin
            // small cluster anywhere in the plane
            bx   = $urandom_range(64000) - 32000;
            by   = $urandom_range(64000) - 32000;
            span = $urandom_range(1) ? 4 : 12;
            foreach (c[i])
                c[i] = ((i % 2) ? by : bx) + $urandom_range(2 * span) - span;
        end else begin
            // endpoints on one line, then optionally bent off it
            bx   = $urandom_range(32000) - 16000;
            by   = $urandom_range(32000) - 16000;
            dmax = $urandom_range(1) ? 3 : 1200;
            dx   = $urandom_range(2 * dmax) - dmax;
            dy   = $urandom_range(2 * dmax) - dmax;
            t0   = $urandom_range(24) - 12;
            t1   = $urandom_range(24) - 12;
            t2   = $urandom_range(24) - 12;
            t3   = $urandom_range(24) - 12;
            mode = $urandom_range(7);
            case (mode)
                1: t1 = t0;
                2: t3 = t2;
                3: begin
                    t1 = t0;
                    t3 = t2;
                end
                4: t2 = t0;
                default: ;
            endcase
            c[0] = bx + t0 * dx;
            c[1] = by + t0 * dy;
            c[2] = bx + t1 * dx;
            c[3] = by + t1 * dy;
            c[4] = bx + t2 * dx;
            c[5] = by + t2 * dy;
            c[6] = bx + t3 * dx;
            c[7] = by + t3 * dy;
            if (mode == 5) begin
                // q leaves p's line from a point on it
                c[6] = c[4] + $urandom_range(1000) - 500;
                c[7] = c[5] + $urandom_range(1000) - 500;
            end else if (mode == 6) begin
                k    = $urandom_range(7);
                c[k] = c[k] + ($urandom_range(1) ? 1 : -1);
            end
        end
        pr = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        return pr;
    endfunction

    task automatic send_pair(input sit_pkg::seg_pair_t pr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pr;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // stop offering and let every expected result come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic set_flow(input int phase);
        case (phase)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 86;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 86;
            end
            default: begin
                send_idle_pct  = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pairs: corners, crossings, collinear and point cases
        set_flow(0);
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, 32766, 32767));
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        send_pair(make_pair(0, 0, 10, 0, 11, 0, 20, 0));
        send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0));
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 7));
        send_pair(make_pair(0, 0, 4, 4, 10, 0, 6, 4));
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        send_pair(make_pair(9, 9, 9, 9, 0, 0, 6, 6));
        send_pair(make_pair(3, 4, 3, 4, 0, 0, 6, 6));
        send_pair(make_pair(0, 0, 6, 6, 2, 2, 2, 2));
        send_pair(make_pair(0, 0, 6, 6, 2, 3, 2, 3));
        send_pair(make_pair(0, 0, 6, 6, -1, -1, -1, -1));
        send_pair(make_pair(1, 2, 1, 2, 1, 3, 1, 3));
        send_pair(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
        send_pair(make_pair(2, 0, 3, 0, 0, 0, 10, 0));
        send_pair(make_pair(12, 0, 13, 0, 0, 0, 10, 0));
        wait_drained();

        // random pairs under each flow-control pattern
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_flow(phase);
            if (phase == 0)
                hold_off_req = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (phase == 0 && i == PRESSURE_ITEMS)
                    wait_drained();
                send_pair(random_pair());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d results never arrived: expected %0d, actual 0",
                     $time, sb.pending(), sb.pending());
        end

        $display("checked %0d segment pairs (%0d meeting, %0d collinear, %0d degenerate)",
                 sb.n_pairs, sb.n_meets, sb.n_collinear, sb.n_degenerate);
        $display("flow patterns: full rate, sparse input, heavy output stall, light mix, ",
                 "long output hold-off; %0d mismatches", sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ segment_intersection_test.f @@
hw/rtl/sit_pkg.sv
hw/rtl/sit_diff_stage.sv
hw/rtl/sit_prod_stage.sv
hw/rtl/sit_decide_stage.sv
hw/rtl/segment_intersection_test.sv
tb/tb_segment_intersection_test.sv
